@@ rtl/core/hue_cycling_hsv_to_rgb_defines.svh @@
// Assertion macros for the hue cycling HSV to RGB block.
// Expects clk_i and rst_ni in the scope of each use; bodies vanish when SYNTH is set.
`ifndef HUE_CYCLING_HSV_TO_RGB_DEFINES_SVH
`define HUE_CYCLING_HSV_TO_RGB_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define HCSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcsv: same-cycle check failed");
// Next-cycle implication.
`define HCSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcsv: next-cycle check failed");
`else
`define HCSV_ASSERT_IMP(lbl, ante, cons)
`define HCSV_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/hcsv_pkg.sv @@
// Shared types and constants of the hue cycling HSV to RGB block.
// No dependencies; used by the color and cfg interfaces, controller, datapath and top level.
`default_nettype none

package hcsv_pkg;

  localparam int HueW     = 9;
  localparam int ChanW    = 8;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 8;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgSat    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgBright = 8'd1;

  localparam logic [ChanW-1:0] SatReset    = 8'd255;
  localparam logic [ChanW-1:0] BrightReset = 8'd26;

  localparam int SectorDeg = 60;
  localparam int FullScale = 255;
  localparam int Divisor   = SectorDeg * FullScale;

  localparam logic [HueW-1:0] Hue60   = 9'd60;
  localparam logic [HueW-1:0] Hue120  = 9'd120;
  localparam logic [HueW-1:0] Hue180  = 9'd180;
  localparam logic [HueW-1:0] Hue240  = 9'd240;
  localparam logic [HueW-1:0] Hue300  = 9'd300;
  localparam logic [HueW-1:0] HueSpan = 9'd360;

  // Numerators peak at 255*255*60, which fits 22 bits.
  localparam int NumW     = 22;
  localparam int RecipW   = 23;
  localparam int DivShift = 36;
  localparam int ProdW    = NumW + RecipW;
  localparam longint unsigned DivRecipL =
      ((64'd1 << DivShift) + 64'(Divisor) - 64'd1) / 64'(Divisor);
  localparam logic [RecipW-1:0] DivRecip = RecipW'(DivRecipL);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_MUL_C,
    OP_MUL_X,
    OP_DIV_R,
    OP_DIV_G,
    OP_DIV_B
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/hcsv_tick_if.sv @@
// Tick channel: one word per color update request.
// Depends on nothing.
`default_nettype none

interface hcsv_tick_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hcsv_color_if.sv @@
// Color channel: one RGB word with the hue it came from.
// Depends on hcsv_pkg for field widths.
`default_nettype none

interface hcsv_color_if;
  logic                        valid;
  logic                        ready;
  logic [hcsv_pkg::ChanW-1:0]  red;
  logic [hcsv_pkg::ChanW-1:0]  green;
  logic [hcsv_pkg::ChanW-1:0]  blue;
  logic [hcsv_pkg::HueW-1:0]   hue_now;

  modport source (output valid, output red, output green, output blue, output hue_now,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input hue_now,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/hcsv_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on hcsv_pkg for field widths.
`default_nettype none

interface hcsv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hcsv_pkg::CfgIdxW-1:0]  index;
  logic [hcsv_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hcsv_ctrl.sv @@
// Sequencer: steps one word through the shared multiplier and hands it to the output.
// Depends on hcsv_pkg for the command struct.
`default_nettype none

module hcsv_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output hcsv_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_C,
    S_MUL_X,
    S_DIV_R,
    S_DIV_G,
    S_DIV_B,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   load_out;

  assign load_out    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = hcsv_pkg::OP_NOP;
    cmd_o.load_out = load_out;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = hcsv_pkg::OP_START;
          state_d  = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd_o.op = hcsv_pkg::OP_MUL_C;
        state_d  = S_MUL_X;
      end
      S_MUL_X: begin
        cmd_o.op = hcsv_pkg::OP_MUL_X;
        state_d  = S_DIV_R;
      end
      S_DIV_R: begin
        cmd_o.op = hcsv_pkg::OP_DIV_R;
        state_d  = S_DIV_G;
      end
      S_DIV_G: begin
        cmd_o.op = hcsv_pkg::OP_DIV_G;
        state_d  = S_DIV_B;
      end
      S_DIV_B: begin
        cmd_o.op = hcsv_pkg::OP_DIV_B;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hcsv_dp.sv @@
// Datapath: hue register, shared multiplier, reciprocal divide by 15300, output word.
// Depends on hcsv_pkg for widths, constants and the command struct.
`default_nettype none

module hcsv_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hcsv_pkg::cmd_t              cmd_i,
  input  wire logic                        advance_i,
  input  wire logic [hcsv_pkg::ChanW-1:0]  sat_i,
  input  wire logic [hcsv_pkg::ChanW-1:0]  bright_i,
  output logic [hcsv_pkg::ChanW-1:0]       red_o,
  output logic [hcsv_pkg::ChanW-1:0]       green_o,
  output logic [hcsv_pkg::ChanW-1:0]       blue_o,
  output logic [hcsv_pkg::HueW-1:0]        hue_now_o
);

  localparam int NumW = hcsv_pkg::NumW;

  typedef enum logic [1:0] {
    TERM_ZERO,
    TERM_C,
    TERM_X
  } term_e;

  // Which term feeds channel chan (0 red, 1 green, 2 blue) in a given 60 degree sector.
  function automatic term_e term_sel(input logic [2:0] sector, input logic [1:0] chan);
    term_e r, g, b, sel;
    case (sector)
      3'd0:    begin r = TERM_C;    g = TERM_X;    b = TERM_ZERO; end
      3'd1:    begin r = TERM_X;    g = TERM_C;    b = TERM_ZERO; end
      3'd2:    begin r = TERM_ZERO; g = TERM_C;    b = TERM_X;    end
      3'd3:    begin r = TERM_ZERO; g = TERM_X;    b = TERM_C;    end
      3'd4:    begin r = TERM_X;    g = TERM_ZERO; b = TERM_C;    end
      default: begin r = TERM_C;    g = TERM_ZERO; b = TERM_X;    end
    endcase
    case (chan)
      2'd0:    sel = r;
      2'd1:    sel = g;
      default: sel = b;
    endcase
    return sel;
  endfunction

  logic [hcsv_pkg::HueW-1:0]  hue_q, hue_d, hue_base, hue_inc;
  logic [hcsv_pkg::HueW-1:0]  hue_off;
  logic [6:0]                 hue_t;
  logic [5:0]                 k_wt;
  logic [2:0]                 sector;
  logic [15:0]                c_q;
  logic [hcsv_pkg::NumW-1:0]  x60_q, x60, c60, m60, term, num;
  logic [hcsv_pkg::ProdW-1:0] prod_q, prod_d;
  logic [hcsv_pkg::NumW-1:0]  mul_a;
  logic [hcsv_pkg::RecipW-1:0] mul_b;
  logic [hcsv_pkg::ChanW-1:0] red_q, green_q, quot;
  logic [1:0]                 chan;
  logic                       mul_en;

  // Hue step with wrap; an out-of-range hue reads as zero.
  assign hue_base = (hue_q >= hcsv_pkg::HueSpan) ? '0 : hue_q;
  assign hue_inc  = hue_base + 9'd1;
  assign hue_d    = advance_i ? ((hue_inc == hcsv_pkg::HueSpan) ? '0 : hue_inc) : hue_base;

  always_comb begin
    if (hue_q < hcsv_pkg::Hue60)       sector = 3'd0;
    else if (hue_q < hcsv_pkg::Hue120) sector = 3'd1;
    else if (hue_q < hcsv_pkg::Hue180) sector = 3'd2;
    else if (hue_q < hcsv_pkg::Hue240) sector = 3'd3;
    else if (hue_q < hcsv_pkg::Hue300) sector = 3'd4;
    else                               sector = 3'd5;
  end

  // hue mod 120, folded to a 0..60 weight
  always_comb begin
    if (hue_q < hcsv_pkg::Hue120)      hue_off = hue_q;
    else if (hue_q < hcsv_pkg::Hue240) hue_off = hue_q - hcsv_pkg::Hue120;
    else                               hue_off = hue_q - hcsv_pkg::Hue240;
    hue_t = hue_off[6:0];
    k_wt  = (hue_t >= 7'(hcsv_pkg::SectorDeg)) ? 6'(7'd120 - hue_t) : hue_t[5:0];
  end

  always_comb begin
    case (cmd_i.op)
      hcsv_pkg::OP_DIV_G: chan = 2'd1;
      hcsv_pkg::OP_DIV_B: chan = 2'd2;
      default:            chan = 2'd0;
    endcase
  end

  // x60 is still in the product register during the red divide
  assign x60 = (cmd_i.op == hcsv_pkg::OP_DIV_R) ? prod_q[hcsv_pkg::NumW-1:0] : x60_q;
  assign c60 = {c_q, 6'b0} - {4'b0, c_q, 2'b0};
  assign m60 = NumW'(bright_i) * NumW'(hcsv_pkg::Divisor) - c60;

  always_comb begin
    case (term_sel(sector, chan))
      TERM_C:  term = c60;
      TERM_X:  term = x60;
      default: term = '0;
    endcase
    num = term + m60;
  end

  always_comb begin
    mul_en = 1'b1;
    case (cmd_i.op)
      hcsv_pkg::OP_MUL_C: begin
        mul_a = NumW'(bright_i);
        mul_b = hcsv_pkg::RecipW'(sat_i);
      end
      hcsv_pkg::OP_MUL_X: begin
        mul_a = NumW'(prod_q[15:0]);
        mul_b = hcsv_pkg::RecipW'(k_wt);
      end
      hcsv_pkg::OP_DIV_R, hcsv_pkg::OP_DIV_G, hcsv_pkg::OP_DIV_B: begin
        mul_a = num;
        mul_b = hcsv_pkg::DivRecip;
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
    prod_d = hcsv_pkg::ProdW'(mul_a) * hcsv_pkg::ProdW'(mul_b);
  end

  assign quot = prod_q[hcsv_pkg::DivShift +: hcsv_pkg::ChanW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '0;
    end else if (cmd_i.op == hcsv_pkg::OP_START) begin
      hue_q <= hue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == hcsv_pkg::OP_MUL_X) begin
      c_q <= prod_q[15:0];
    end
    if (cmd_i.op == hcsv_pkg::OP_DIV_R) begin
      x60_q <= prod_q[hcsv_pkg::NumW-1:0];
    end
    if (cmd_i.op == hcsv_pkg::OP_DIV_G) begin
      red_q <= quot;
    end
    if (cmd_i.op == hcsv_pkg::OP_DIV_B) begin
      green_q <= quot;
    end
    if (cmd_i.load_out) begin
      red_o     <= red_q;
      green_o   <= green_q;
      blue_o    <= quot;
      hue_now_o <= hue_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hue_cycling_hsv_to_rgb.sv @@
// Top level of the hue cycling HSV to RGB block.
// Depends on hcsv_pkg, the three channel interfaces, hcsv_ctrl, hcsv_dp and the defines header.
`default_nettype none

// Each tick word optionally steps the hue by one degree (wrapping at 360) and
// yields one RGB word for the current hue at the configured saturation and
// brightness. A word goes in order through the accept cycle, then five passes through
// one shared 22x23 multiplier (chroma v*s, x term, and one reciprocal multiply
// per channel for the divide by 15300), then the load of the output register.
// The next tick word is taken in the cycle after that load, while the finished
// color may still wait in the output register. Configuration writes are always
// accepted; unknown register indexes are ignored.
`include "hue_cycling_hsv_to_rgb_defines.svh"

module hue_cycling_hsv_to_rgb (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  hcsv_tick_if.sink    tick_i,
  hcsv_color_if.source color_o,
  hcsv_cfg_if.sink     cfg_i
);

  logic [hcsv_pkg::ChanW-1:0] sat_q;
  logic [hcsv_pkg::ChanW-1:0] bright_q;
  hcsv_pkg::cmd_t             cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q    <= hcsv_pkg::SatReset;
      bright_q <= hcsv_pkg::BrightReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hcsv_pkg::CfgSat:    sat_q    <= cfg_i.data;
        hcsv_pkg::CfgBright: bright_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  hcsv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_ready_o  (tick_i.ready),
    .out_ready_i (color_o.ready),
    .out_valid_o (color_o.valid),
    .cmd_o       (cmd)
  );

  hcsv_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .advance_i (tick_i.advance),
    .sat_i     (sat_q),
    .bright_i  (bright_q),
    .red_o     (color_o.red),
    .green_o   (color_o.green),
    .blue_o    (color_o.blue),
    .hue_now_o (color_o.hue_now)
  );

  `HCSV_ASSERT_IMP(a_hue_range, color_o.valid, color_o.hue_now < hcsv_pkg::HueSpan)
  `HCSV_ASSERT_NXT(a_busy_after_accept, tick_i.valid && tick_i.ready, !tick_i.ready)
  `HCSV_ASSERT_IMP(a_chan_bound, color_o.valid, (color_o.red <= bright_q) && (color_o.green <= bright_q) && (color_o.blue <= bright_q))

endmodule

`default_nettype wire

@@ bench/hue_cycling_hsv_to_rgb_tb.sv @@
// Testbench for hue_cycling_hsv_to_rgb: random tick traffic against a local color predictor.
// Depends on hcsv_pkg, the tick, color and cfg channel interfaces, and the block itself.
module hue_cycling_hsv_to_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 11;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 20;
  localparam int MaxGap      = 14;
  localparam int HoldAt      = 500;
  localparam int HoldCycles  = 400;
  localparam int PhaseCount  = 10;
  localparam int PhaseTicks  = 115;
  localparam int BurstLen    = 25;
  localparam int MaxReports  = 10;

  typedef enum logic [1:0] {ITEM_TICK, ITEM_CFG, ITEM_SYNC} item_kind_e;

  typedef struct {
    item_kind_e                      kind;
    logic                            advance;
    logic [hcsv_pkg::CfgIdxW-1:0]    index;
    logic [hcsv_pkg::CfgDataW-1:0]   data;
    int                              gap;
  } stim_item_t;

  typedef struct packed {
    logic [hcsv_pkg::ChanW-1:0] red;
    logic [hcsv_pkg::ChanW-1:0] green;
    logic [hcsv_pkg::ChanW-1:0] blue;
    logic [hcsv_pkg::HueW-1:0]  hue_now;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcsv_tick_if  tick_if ();
  hcsv_color_if color_if ();
  hcsv_cfg_if   cfg_if ();

  hue_cycling_hsv_to_rgb DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_if),
    .color_o (color_if),
    .cfg_i   (cfg_if)
  );

  stim_item_t stim_q[$];
  color_t     expected_colors[$];

  logic [hcsv_pkg::HueW-1:0]  hue_model    = '0;
  logic [hcsv_pkg::ChanW-1:0] sat_model    = hcsv_pkg::SatReset;
  logic [hcsv_pkg::ChanW-1:0] bright_model = hcsv_pkg::BrightReset;

  int ticks_taken  = 0;
  int cfg_writes   = 0;
  int hue_wraps    = 0;
  int results_seen = 0;
  int err_count    = 0;
  int gap_wait     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  logic hold_done  = 1'b0;
  logic rx_fast    = 1'b0;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Color for a hue at the given saturation and brightness, exact integer math.
  function automatic color_t predict_color(logic [hcsv_pkg::HueW-1:0] hue,
                                           logic [hcsv_pkg::ChanW-1:0] sat,
                                           logic [hcsv_pkg::ChanW-1:0] val);
    int unsigned chroma, offset60, full60, x60, phase, weight;
    int unsigned red_t, green_t, blue_t;
    color_t c;
    chroma   = 32'(val) * 32'(sat);
    offset60 = (32'(val) * hcsv_pkg::FullScale - chroma) * hcsv_pkg::SectorDeg;
    full60   = chroma * hcsv_pkg::SectorDeg;
    phase    = 32'(hue) % (2 * hcsv_pkg::SectorDeg);
    weight   = (phase >= hcsv_pkg::SectorDeg) ? (2 * hcsv_pkg::SectorDeg - phase) : phase;
    x60      = chroma * weight;
    case (32'(hue) / hcsv_pkg::SectorDeg)
      0: begin red_t = full60; green_t = x60;    blue_t = 0;      end
      1: begin red_t = x60;    green_t = full60; blue_t = 0;      end
      2: begin red_t = 0;      green_t = full60; blue_t = x60;    end
      3: begin red_t = 0;      green_t = x60;    blue_t = full60; end
      4: begin red_t = x60;    green_t = 0;      blue_t = full60; end
      default: begin red_t = full60; green_t = 0; blue_t = x60; end
    endcase
    c.red     = hcsv_pkg::ChanW'((red_t + offset60) / hcsv_pkg::Divisor);
    c.green   = hcsv_pkg::ChanW'((green_t + offset60) / hcsv_pkg::Divisor);
    c.blue    = hcsv_pkg::ChanW'((blue_t + offset60) / hcsv_pkg::Divisor);
    c.hue_now = hue;
    return c;
  endfunction

  function automatic void add_tick(logic adv, int gap);
    stim_item_t it;
    it = '{kind: ITEM_TICK, advance: adv, index: '0, data: '0, gap: gap};
    stim_q.push_back(it);
  endfunction

  function automatic void add_cfg(logic [hcsv_pkg::CfgIdxW-1:0] idx,
                                  logic [hcsv_pkg::CfgDataW-1:0] val);
    stim_item_t it;
    it = '{kind: ITEM_CFG, advance: 1'b0, index: idx, data: val, gap: 0};
    stim_q.push_back(it);
  endfunction

  function automatic void add_sync();
    stim_item_t it;
    it = '{kind: ITEM_SYNC, advance: 1'b0, index: '0, data: '0, gap: 0};
    stim_q.push_back(it);
  endfunction

  // Extremes come up often; the rest spread over the full byte.
  function automatic logic [hcsv_pkg::CfgDataW-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return hcsv_pkg::CfgDataW'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MaxGap);
      default: return ($urandom_range(0, 7) == 0) ? MaxGap : 0;
    endcase
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MaxReports) $display("%s", msg);
  endtask

  // Driver: one word at a time from the stimulus queue; register writes only when idle.
  always @(posedge clk_i) begin
    logic next_tick_valid;
    logic next_cfg_valid;
    stim_item_t head;
    if (rst_ni) begin
      next_tick_valid = tick_if.valid;
      next_cfg_valid  = cfg_if.valid;
      if (tick_if.valid && tick_if.ready) begin
        if (tick_if.advance) begin
          if (hue_model >= hcsv_pkg::HueSpan - 1) begin
            hue_model = '0;
            hue_wraps++;
          end else begin
            hue_model = hue_model + 1'b1;
          end
        end
        expected_colors.push_back(predict_color(hue_model, sat_model, bright_model));
        ticks_taken <= ticks_taken + 1;
        next_tick_valid = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          hcsv_pkg::CfgSat:    sat_model = cfg_if.data;
          hcsv_pkg::CfgBright: bright_model = cfg_if.data;
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
        next_cfg_valid = 1'b0;
      end
      if (!next_tick_valid && !next_cfg_valid && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.kind)
          ITEM_TICK: begin
            if (gap_wait < head.gap) begin
              gap_wait++;
            end else begin
              void'(stim_q.pop_front());
              gap_wait = 0;
              next_tick_valid = 1'b1;
              tick_if.advance <= head.advance;
            end
          end
          ITEM_CFG: begin
            if (expected_colors.size() == 0) begin
              void'(stim_q.pop_front());
              next_cfg_valid = 1'b1;
              cfg_if.index <= head.index;
              cfg_if.data  <= head.data;
            end
          end
          default: begin
            if (expected_colors.size() == 0) void'(stim_q.pop_front());
          end
        endcase
      end
      tick_if.valid <= next_tick_valid;
      cfg_if.valid  <= next_cfg_valid;
    end
  end

  // Long receiver hold-off once, with the sender still pushing.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && ticks_taken >= HoldAt) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: check each color word against the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    color_t got;
    color_t want;
    if (rst_ni) begin
      if (color_if.valid && color_if.ready) begin
        got = '{red: color_if.red, green: color_if.green, blue: color_if.blue,
                hue_now: color_if.hue_now};
        results_seen++;
        if (expected_colors.size() == 0) begin
          flag_error($sformatf("unexpected color word: r=%0d g=%0d b=%0d hue=%0d",
                               got.red, got.green, got.blue, got.hue_now));
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.hue_now !== want.hue_now)
            flag_error($sformatf(
              {"mismatch at word %0d: expected r=%0d g=%0d b=%0d hue=%0d,",
               " got r=%0d g=%0d b=%0d hue=%0d"},
              results_seen, want.red, want.green, want.blue, want.hue_now,
              got.red, got.green, got.blue, got.hue_now));
        end
        if (results_seen % 50 == 0) rx_fast = ($urandom_range(0, 3) == 0);
        stall_left = rx_fast ? 0 : $urandom_range(0, MaxGap);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      color_if.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_colors.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int mode;
    int sync_at;
    tick_if.valid   = 1'b0;
    tick_if.advance = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    color_if.ready  = 1'b0;

    // Directed: reset levels, gray, full color, black, ignored writes.
    add_tick(1'b0, 0);
    add_tick(1'b1, 0);
    add_tick(1'b0, 3);
    add_tick(1'b1, 0);
    add_cfg(hcsv_pkg::CfgSat, '0);
    add_cfg(hcsv_pkg::CfgBright, '1);
    add_tick(1'b1, 0);
    add_tick(1'b0, 0);
    add_cfg(hcsv_pkg::CfgSat, '1);
    add_tick(1'b1, 0);
    add_tick(1'b1, MaxGap);
    add_tick(1'b0, 0);
    add_cfg(hcsv_pkg::CfgBright, '0);
    add_tick(1'b1, 0);
    add_tick(1'b0, 0);
    add_cfg(hcsv_pkg::CfgBright + 1'b1, 8'hA5);
    add_cfg('1, 8'h5A);
    add_tick(1'b1, 0);
    add_tick(1'b1, 0);
    add_cfg(hcsv_pkg::CfgBright, '1);
    add_tick(1'b0, 0);
    add_tick(1'b1, 0);

    // Random phases: new levels each phase, advance mostly set so the hue sweeps and wraps.
    for (int p = 0; p < PhaseCount; p++) begin
      add_sync();
      add_cfg(hcsv_pkg::CfgSat, pick_level());
      add_cfg(hcsv_pkg::CfgBright, pick_level());
      if ($urandom_range(0, 2) == 0)
        add_cfg(hcsv_pkg::CfgIdxW'($urandom_range(int'(hcsv_pkg::CfgBright) + 1, 255)),
                hcsv_pkg::CfgDataW'($urandom_range(0, 255)));
      sync_at = $urandom_range(10, PhaseTicks - 10);
      mode = 0;
      for (int n = 0; n < PhaseTicks; n++) begin
        if (n % BurstLen == 0) mode = $urandom_range(0, 2);
        if (n == sync_at) add_sync();
        add_tick($urandom_range(0, 7) != 0, pick_gap(mode));
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || tick_if.valid || cfg_if.valid || expected_colors.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d ticks and %0d checked color words over %0d register writes,",
             ticks_taken, results_seen, cfg_writes);
    $display("with %0d hue wraps, saturation and brightness from 0 to 255, %0d mismatches",
             hue_wraps, err_count);
    if (err_count == 0 && expected_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ hue_cycling_hsv_to_rgb.f @@
+incdir+rtl/core
rtl/core/hcsv_pkg.sv
rtl/core/hcsv_tick_if.sv
rtl/core/hcsv_color_if.sv
rtl/core/hcsv_cfg_if.sv
rtl/core/hcsv_ctrl.sv
rtl/core/hcsv_dp.sv
rtl/core/hue_cycling_hsv_to_rgb.sv
bench/hue_cycling_hsv_to_rgb_tb.sv
